// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the Base64 stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
  } out_t;

  // one decoded character's worth of work for the back end
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Takes characters, maps them to sextets, keeps the partial group and builds
// one job per character that has bytes or ends the message.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           char_valid,
  output logic                char_ready,
  input  wire b64d_pkg::in_t  char_data,
  output logic                job_valid,
  input  wire logic           job_ready,
  output b64d_pkg::job_t      job_data
);
  import b64d_pkg::*;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5a;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7a;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_SLSH = 8'h2f;

  // {in alphabet, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
        d = ch - CH_UP_A;
        return {1'b1, d[5:0]};
      end
      if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
        d = ch - CH_LO_A + 8'd26;
        return {1'b1, d[5:0]};
      end
      if (ch >= CH_D0 && ch <= CH_D9) begin
        d = ch - CH_D0 + 8'd52;
        return {1'b1, d[5:0]};
      end
      if (ch == CH_PLUS) return {1'b1, 6'd62};
      if (ch == CH_SLSH) return {1'b1, 6'd63};
      return {1'b0, 6'd0};
    end
  endfunction

  logic [5:0] held [3];
  logic [1:0] fill;
  logic       stopped;

  logic [6:0] sx;
  logic       alpha;
  logic [5:0] v;
  logic [5:0] s [4];
  logic [1:0] n;
  logic       acc;

  always_comb begin
    sx    = sextet_of(char_data.char_code);
    alpha = sx[6];
    v     = sx[5:0];
    for (int i = 0; i < 3; i++) begin
      s[i] = (fill == 2'(i)) ? v : held[i];
    end
    s[3] = v;

    n = 2'd0;
    if (!stopped) begin
      if (!alpha) begin
        n = (fill >= 2'd2) ? fill - 2'd1 : 2'd0;
      end else if (fill == 2'd3) begin
        n = 2'd3;
      end else if (char_data.last_char) begin
        n = fill;
      end
    end

    job_data.bytes[0] = {s[0], s[1][5:4]};
    job_data.bytes[1] = {s[1][3:0], s[2][5:2]};
    job_data.bytes[2] = {s[2][1:0], s[3]};
    job_data.count    = n;
    job_data.last     = char_data.last_char;
  end

  assign char_ready = job_ready;
  assign job_valid  = char_valid && (n != 2'd0 || char_data.last_char);
  assign acc        = char_valid && char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 2'd0;
      stopped <= 1'b0;
    end else if (acc) begin
      if (char_data.last_char) begin
        fill    <= 2'd0;
        stopped <= 1'b0;
      end else if (!stopped) begin
        if (!alpha) begin
          stopped <= 1'b1;
          fill    <= 2'd0;
        end else begin
          fill <= fill + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !stopped && alpha) begin
      for (int i = 0; i < 3; i++) begin
        if (fill == 2'(i)) held[i] <= v;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc && char_data.last_char |=> fill == 2'd0 && !stopped)
    else $error("state not cleared after message end");

  a_stop_empty: assert property (@(posedge clk) disable iff (rst)
    stopped |-> fill == 2'd0)
    else $error("group held while stopped");

endmodule

`default_nettype wire

// ----- sv/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Small job FIFO that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire b64d_pkg::job_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output b64d_pkg::job_t       pop_data
);
  import b64d_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != QCNT_W'(QDEPTH) && count != '0 |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- sv/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Result sequencer: steps through each job's bytes, one result per cycle
// while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire b64d_pkg::job_t  job_data,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output b64d_pkg::out_t       res_data
);
  import b64d_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;

  logic       emit;
  logic       final_res;
  out_t       res_next;

  always_comb begin
    final_res = (cur.count == 2'd0) || (idx == cur.count - 2'd1);
    emit      = cur_valid && (!res_valid || res_ready);
    res_next.byte_valid  = cur.count != 2'd0;
    res_next.data_byte   = 8'd0;
    if (cur.count != 2'd0) begin
      case (idx)
        2'd0:    res_next.data_byte = cur.bytes[0];
        2'd1:    res_next.data_byte = cur.bytes[1];
        2'd2:    res_next.data_byte = cur.bytes[2];
        default: res_next.data_byte = 8'd0;
      endcase
    end
    res_next.run_last    = final_res;
    res_next.message_end = final_res && cur.last;
  end

  assign job_ready = !cur_valid || (emit && final_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (job_valid && job_ready) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (emit) begin
        if (final_res) cur_valid <= 1'b0;
        else idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) cur <= job_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_data <= res_next;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.count != 2'd0 |-> idx < cur.count)
    else $error("byte index past job count");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.byte_valid |->
      res_data.run_last && res_data.message_end && res_data.data_byte == 8'd0)
    else $error("malformed end marker");

endmodule

`default_nettype wire

// ----- sv/base64_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 (standard alphabet) stream decoder, one character per transaction.
// ----------------------------------------------------------------------------
// Takes one character per clock while the job queue has room. Each character
// gives zero to three result transactions, issued one per clock from a
// registered output unless it stalls; a full group of four characters yields
// three bytes, so a continuous stream runs at one character per cycle. A
// four-entry job queue between the character front end and the result
// sequencer absorbs bursts, and the input stalls only when that queue is full.
// '=' or any non-alphabet character ends decoding until the character flagged
// last, which always closes the message with message_end.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           char_valid,
  output logic                char_ready,
  input  wire b64d_pkg::in_t  char_data,
  output logic                res_valid,
  input  wire logic           res_ready,
  output b64d_pkg::out_t      res_data
);
  import b64d_pkg::*;

  logic f_valid;
  logic f_ready;
  job_t f_data;
  logic q_valid;
  logic q_ready;
  job_t q_data;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job_data   (f_data)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
